/* design/ldt_pkg.sv */
package ldt_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 24;

	localparam int REG_IDX_BITS = 3;
	localparam int REG_BITS     = 64;

	localparam logic [REG_IDX_BITS-1:0] REG_RATIO_ZERO   = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_LOWER_ZERO   = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_UPPER_ZERO   = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_RATIO_ONE    = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_LOWER_ONE    = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_UPPER_ONE    = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_LENGTH_LIMIT = 3'd6;

	localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [1:0][31:0] ratio;
		logic [1:0][63:0] lower;
		logic [1:0][63:0] upper;
		logic [31:0]      limit;
	} ldt_cfg_t;

	// packed MSB first: echo_letter lands in bit 0
	typedef struct packed {
		logic        limit_reached;
		logic [31:0] violation_at;
		logic [31:0] max_where;
		logic [63:0] max_value;
		logic [31:0] min_where;
		logic [63:0] min_value;
		logic        new_violation;
		logic [63:0] discrepancy;
		logic [31:0] letter_index;
		logic [31:0] position;
		logic        echo_letter;
	} ldt_result_t;

endpackage

/* design/ldt_disc.sv */
module ldt_disc #(
	parameter int COUNT_BITS = ldt_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = ldt_pkg::FRAC_BITS_DEF
) (
	input  logic [COUNT_BITS-1:0] count,
	input  logic [31:0]           ratio,
	input  logic [COUNT_BITS-1:0] pos,
	output logic [63:0]           disc
);
	import ldt_pkg::*;

	localparam int PW = COUNT_BITS + 32;
	localparam int W  = COUNT_BITS + 34;
	localparam int WX = ((W > 64) ? W : 64) + 1;

	logic [PW-1:0]        prod;
	logic [W-1:0]         minuend;
	logic [W-1:0]         subtrahend;
	logic [W-1:0]         diff;
	logic signed [WX-1:0] diff_x;
	logic signed [WX-1:0] sat_hi;
	logic signed [WX-1:0] sat_lo;

	assign prod       = PW'(count) * PW'(ratio);
	assign minuend    = W'(prod);
	assign subtrahend = W'(pos) << FRAC_BITS;
	assign diff       = minuend - subtrahend;
	assign diff_x     = WX'($signed(diff));
	assign sat_hi     = WX'(INT64_MAX);
	assign sat_lo     = WX'(INT64_MIN);

	always_comb begin
		if (diff_x > sat_hi) begin
			disc = INT64_MAX;
		end else if (diff_x < sat_lo) begin
			disc = INT64_MIN;
		end else begin
			disc = diff_x[63:0];
		end
	end

endmodule

/* design/ldt_state.sv */
module ldt_state #(
	parameter int COUNT_BITS = ldt_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = ldt_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                update,
	input  logic                letter,
	input  ldt_pkg::ldt_cfg_t   cfg,
	output ldt_pkg::ldt_result_t result
);
	import ldt_pkg::*;

	logic [COUNT_BITS-1:0] pos_q;
	logic [COUNT_BITS-1:0] cnt_q       [2];
	logic [63:0]           least_q     [2];
	logic [63:0]           greatest_q  [2];
	logic [COUNT_BITS-1:0] least_idx_q [2];
	logic [COUNT_BITS-1:0] great_idx_q [2];
	logic [COUNT_BITS-1:0] bad_idx_q   [2];
	logic                  done_q;

	logic [COUNT_BITS-1:0] pos_next;
	logic [COUNT_BITS-1:0] cnt_next;
	logic [63:0]           disc;
	logic                  first;
	logic                  take_min;
	logic                  take_max;
	logic                  in_bounds;
	logic                  mark_bad;
	logic                  limit_hit;
	logic [63:0]           pos_x;
	logic [63:0]           cnt_x;
	logic [63:0]           least_idx_x;
	logic [63:0]           great_idx_x;
	logic [63:0]           bad_idx_x;
	logic [63:0]           pos_cur_x;
	logic [63:0]           cnt_cur_x;

	assign pos_next = pos_q + COUNT_BITS'(1);
	assign cnt_next = cnt_q[letter] + COUNT_BITS'(1);

	ldt_disc #(
		.COUNT_BITS(COUNT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_disc (
		.count(cnt_next),
		.ratio(cfg.ratio[letter]),
		.pos  (pos_next),
		.disc (disc)
	);

	assign first     = (cnt_next == COUNT_BITS'(1));
	assign take_min  = first || ($signed(disc) < $signed(least_q[letter]));
	assign take_max  = first || ($signed(greatest_q[letter]) < $signed(disc));
	assign in_bounds = ($signed(cfg.lower[letter]) < $signed(disc)) &&
	                   ($signed(disc) < $signed(cfg.upper[letter]));
	assign mark_bad  = (bad_idx_q[letter] == '0) && !in_bounds;
	assign limit_hit = (64'(pos_next) >= 64'(cfg.limit));

	assign pos_x       = 64'(pos_next);
	assign cnt_x       = 64'(cnt_next);
	assign pos_cur_x   = 64'(pos_q);
	assign cnt_cur_x   = 64'(cnt_q[letter]);
	assign least_idx_x = 64'(least_idx_q[letter]);
	assign great_idx_x = 64'(great_idx_q[letter]);
	assign bad_idx_x   = 64'(bad_idx_q[letter]);

	always_comb begin
		result.echo_letter = letter;
		if (done_q) begin
			result.position      = pos_cur_x[31:0];
			result.letter_index  = cnt_cur_x[31:0];
			result.discrepancy   = '0;
			result.new_violation = 1'b0;
			result.min_value     = least_q[letter];
			result.min_where     = least_idx_x[31:0];
			result.max_value     = greatest_q[letter];
			result.max_where     = great_idx_x[31:0];
			result.violation_at  = bad_idx_x[31:0];
			result.limit_reached = 1'b1;
		end else begin
			result.position      = pos_x[31:0];
			result.letter_index  = cnt_x[31:0];
			result.discrepancy   = disc;
			result.new_violation = mark_bad && (cnt_next != '0);
			result.min_value     = take_min ? disc : least_q[letter];
			result.min_where     = take_min ? cnt_x[31:0] : least_idx_x[31:0];
			result.max_value     = take_max ? disc : greatest_q[letter];
			result.max_where     = take_max ? cnt_x[31:0] : great_idx_x[31:0];
			result.violation_at  = mark_bad ? cnt_x[31:0] : bad_idx_x[31:0];
			result.limit_reached = limit_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				cnt_q[i]       <= '0;
				least_q[i]     <= '0;
				greatest_q[i]  <= '0;
				least_idx_q[i] <= '0;
				great_idx_q[i] <= '0;
				bad_idx_q[i]   <= '0;
			end
		end else if (update && !done_q) begin
			pos_q         <= pos_next;
			cnt_q[letter] <= cnt_next;
			if (take_min) begin
				least_q[letter]     <= disc;
				least_idx_q[letter] <= cnt_next;
			end
			if (take_max) begin
				greatest_q[letter]  <= disc;
				great_idx_q[letter] <= cnt_next;
			end
			if (mark_bad) begin
				bad_idx_q[letter] <= cnt_next;
			end
			if (limit_hit) begin
				done_q <= 1'b1;
			end
		end
	end

endmodule

/* design/letter_discrepancy_tracker_top.sv */
// The result is registered: input register letter_s1, then result register result_q;
// a stall on m_axis_tready holds both registers until the output transaction is taken.
// Throughput: one letter per cycle while m_axis_tready does not stall; the per-letter state update,
// one COUNT_BITS x 32 multiply plus saturate and compares, is combinational between the registers.
// s_axis_tready follows m_axis_tready combinationally; one transaction is taken while a result waits.
// Reset: arst_n asynchronous active low; clears counters, records and limit flag,
// loads configuration defaults (ratios 1.0, widest bounds, limit all ones).
module letter_discrepancy_tracker_top #(
	parameter int COUNT_BITS = ldt_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = ldt_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [0] letter
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] echo_letter, [32:1] position, [64:33] letter_index, [128:65] discrepancy,
	// [129] new_violation, [193:130] min_value, [225:194] min_where,
	// [289:226] max_value, [321:290] max_where, [353:322] violation_at,
	// [354] limit_reached, [359:355] zero
	output logic [359:0]                      m_axis_tdata,
	input  logic                              wr_en,
	input  logic [ldt_pkg::REG_IDX_BITS-1:0]  wr_index,
	input  logic [ldt_pkg::REG_BITS-1:0]      wr_data
);
	import ldt_pkg::*;

	localparam logic [31:0] RatioOne = 32'((64'd1) << FRAC_BITS);

	ldt_cfg_t    cfg_q;
	logic        s1_valid_q;
	logic        letter_s1;
	logic        m_valid_q;
	ldt_result_t result_q;
	ldt_result_t result;
	logic        advance;
	logic        take;

	assign advance       = !m_valid_q || m_axis_tready;
	assign take          = s1_valid_q && advance;
	assign s_axis_tready = !s1_valid_q || advance;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'b0, result_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ratio[0] <= RatioOne;
			cfg_q.ratio[1] <= RatioOne;
			cfg_q.lower[0] <= INT64_MIN;
			cfg_q.lower[1] <= INT64_MIN;
			cfg_q.upper[0] <= INT64_MAX;
			cfg_q.upper[1] <= INT64_MAX;
			cfg_q.limit    <= 32'hFFFF_FFFF;
		end else if (wr_en) begin
			case (wr_index)
				REG_RATIO_ZERO:   cfg_q.ratio[0] <= wr_data[31:0];
				REG_LOWER_ZERO:   cfg_q.lower[0] <= wr_data;
				REG_UPPER_ZERO:   cfg_q.upper[0] <= wr_data;
				REG_RATIO_ONE:    cfg_q.ratio[1] <= wr_data[31:0];
				REG_LOWER_ONE:    cfg_q.lower[1] <= wr_data;
				REG_UPPER_ONE:    cfg_q.upper[1] <= wr_data;
				REG_LENGTH_LIMIT: cfg_q.limit    <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				s1_valid_q <= s_axis_tvalid;
			end
			if (advance) begin
				m_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			letter_s1 <= s_axis_tdata[0];
		end
		if (take) begin
			result_q <= result;
		end
	end

	ldt_state #(
		.COUNT_BITS(COUNT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_state (
		.clk   (clk),
		.arst_n(arst_n),
		.update(take),
		.letter(letter_s1),
		.cfg   (cfg_q),
		.result(result)
	);

endmodule

/* design/ldt_checker.sv */
module ldt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [7:0]   s_axis_tdata,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [359:0] m_axis_tdata
);

	logic [1:0] pend_q;
	logic       lim_seen_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] || !s_axis_tdata[0]);
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			lim_seen_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
			if (out_xfer && m_axis_tdata[354]) begin
				lim_seen_q <= 1'b1;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != 2'd3) && (!m_axis_tvalid || pend_q != 2'd0))
		else $error("result without matching input transaction");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && lim_seen_q |-> m_axis_tdata[354])
		else $error("limit flag dropped after being reported");

	a_viol: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[129] |-> m_axis_tdata[353:322] == m_axis_tdata[64:33])
		else $error("new violation not recorded at this letter index");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $signed(m_axis_tdata[193:130]) <= $signed(m_axis_tdata[289:226]))
		else $error("min record above max record");

endmodule

bind letter_discrepancy_tracker_top ldt_checker u_ldt_checker (.*);
